// ===== design/lcmd_pkg.sv =====
// shared constants, types and helpers for the minimum distance block
package lcmd_pkg;

  localparam int MAX_ROWS         = 64;
  localparam int MAX_MESSAGE_BITS = 16;
  localparam int ROW_W            = 16;
  localparam int ADDR_W           = $clog2(MAX_ROWS);
  localparam int CNT_W            = ADDR_W + 1;
  localparam int DIST_W           = 7;
  localparam int HBITS_W          = 5;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DIST_W-1:0] dist_t;

  // command from the loader to the enumeration engine
  typedef struct packed {
    logic start;
    cnt_t rows;
    row_t mask;
  } eng_cmd_t;

  // engine status back to the top level
  typedef struct packed {
    logic  idle;
    logic  res_valid;
    dist_t best;
  } eng_stat_t;

  // all-ones mask of the message width, width saturated to the row width
  function automatic row_t msg_mask(input logic [HBITS_W-1:0] h);
    logic [HBITS_W-1:0] hs;
    logic [ROW_W:0]     full;
    hs   = (h > HBITS_W'(MAX_MESSAGE_BITS)) ? HBITS_W'(MAX_MESSAGE_BITS) : h;
    full = ((ROW_W+1)'(1) << hs) - (ROW_W+1)'(1);
    return full[ROW_W-1:0];
  endfunction

endpackage

// ===== design/lcmd_row_ram.sv =====
// generator row memory, one write port and one registered read port
module lcmd_row_ram
  import lcmd_pkg::*;
(
  input  logic  clk,
  input  logic  we,
  input  addr_t waddr,
  input  row_t  wdata,
  input  logic  re,
  input  addr_t raddr,
  output row_t  rdata
);

  row_t mem [MAX_ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/lcmd_engine.sv =====
// message enumeration engine: sweeps the row memory once per message
module lcmd_engine
  import lcmd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  eng_cmd_t  cmd,
  input  logic      res_ack,
  output logic      rd_en,
  output addr_t     rd_addr,
  input  row_t      rd_data,
  output eng_stat_t stat
);

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_RUN  = 4'b0010,
    E_WAIT = 4'b0100,
    E_HOLD = 4'b1000
  } eng_state_t;

  eng_state_t state;

  cnt_t  rows_r;
  row_t  mask_r;
  addr_t k;
  row_t  msg;
  dist_t acc;
  dist_t best;

  logic  s1_valid;
  logic  s1_first;
  logic  s1_last;
  logic  s1_final;
  row_t  s1_msg;

  logic  issue_last;
  logic  par;
  dist_t sum;

  assign issue_last = ({1'b0, k} == (rows_r - cnt_t'(1)));
  assign rd_en      = (state == E_RUN);
  assign rd_addr    = k;

  // parity of one codeword bit, added to the running weight
  assign par = ^(rd_data & s1_msg);
  assign sum = (s1_first ? dist_t'(0) : acc) + dist_t'(par);

  assign stat.idle      = (state == E_IDLE);
  assign stat.res_valid = (state == E_HOLD);
  assign stat.best      = best;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_IDLE;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (state == E_RUN);
      unique case (state)
        E_IDLE: begin
          if (cmd.start) begin
            state <= (cmd.mask == '0) ? E_HOLD : E_RUN;
          end
        end
        E_RUN: begin
          if (issue_last && msg == mask_r) begin
            state <= E_WAIT;
          end
        end
        E_WAIT: begin
          if (s1_valid && s1_final) begin
            state <= E_HOLD;
          end
        end
        E_HOLD: begin
          if (res_ack) begin
            state <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= (k == '0);
    s1_last  <= issue_last;
    s1_final <= issue_last && (msg == mask_r);
    s1_msg   <= msg;
    if (state == E_IDLE && cmd.start) begin
      rows_r <= cmd.rows;
      mask_r <= cmd.mask;
      best   <= dist_t'(cmd.rows);
      k      <= '0;
      msg    <= row_t'(1);
    end else begin
      if (state == E_RUN) begin
        if (issue_last) begin
          k   <= '0;
          msg <= msg + row_t'(1);
        end else begin
          k <= k + addr_t'(1);
        end
      end
      if (s1_valid) begin
        acc <= sum;
        // end of one message sweep: keep the smallest nonzero weight
        if (s1_last && sum != '0 && sum < best) begin
          best <= sum;
        end
      end
    end
  end

  a_s1_in_sweep: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (state == E_RUN || state == E_WAIT))
    else $error("row data in flight outside a sweep");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (state != E_IDLE) |-> !cmd.start)
    else $error("start while engine busy");

  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    (state == E_HOLD) |-> (cnt_t'(best) <= rows_r))
    else $error("distance above row count");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (state == E_RUN) |-> ({1'b0, k} < rows_r))
    else $error("row address past loaded rows");

endmodule

// ===== design/linear_code_min_distance.sv =====
// Brute-force minimum distance of a binary linear code. Generator rows arrive one per transfer
// on the s_ side and are taken one per cycle while the engine is idle into a 64-entry row
// memory; rows past 64 are dropped and flagged. The transfer with tlast set starts the
// enumeration: for every nonzero message of message_bits bits (saturated to 16) the engine
// reads every stored row once, one row per cycle from the single read port of the row memory.
// When message_bits is 0 no message is enumerated. No row is accepted until the result,
// the distance and the overflow flag, has moved into an output register on the m_ side,
// where it then waits. message_bits is written through the APB port at addresses 0 to 3.
module linear_code_min_distance
  import lcmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // row input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // row_mask[15:0]
  input  logic        s_tlast,   // last_row
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // distance[6:0], zero pad [7]
  output logic        m_tuser    // overflow
);

  logic [HBITS_W-1:0] message_bits;
  cnt_t               rows_loaded;
  logic               overflow_seen;
  logic               ovf_res;

  eng_cmd_t  cmd;
  eng_stat_t stat;
  logic      res_ack;
  logic      xfer;
  logic      room;
  logic      we;
  logic      rd_en;
  addr_t     rd_addr;
  row_t      rd_data;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32-HBITS_W){1'b0}}, message_bits} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      message_bits <= HBITS_W'(1);
    end else if (cfg_wr) begin
      message_bits <= pwdata[HBITS_W-1:0];
    end
  end

  assign s_tready = stat.idle;
  assign xfer     = s_tvalid && s_tready;
  assign room     = (rows_loaded < cnt_t'(MAX_ROWS));
  assign we       = xfer && room;

  assign cmd.start = xfer && s_tlast;
  assign cmd.rows  = room ? rows_loaded + cnt_t'(1) : rows_loaded;
  assign cmd.mask  = msg_mask(message_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded   <= '0;
      overflow_seen <= 1'b0;
    end else if (xfer) begin
      if (s_tlast) begin
        rows_loaded   <= '0;
        overflow_seen <= 1'b0;
      end else begin
        if (room) begin
          rows_loaded <= rows_loaded + cnt_t'(1);
        end
        overflow_seen <= overflow_seen | !room;
      end
    end
  end

  // overflow flag of the matrix under evaluation
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ovf_res <= overflow_seen | !room;
    end
  end

  lcmd_row_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (rows_loaded[ADDR_W-1:0]),
    .wdata (s_tdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lcmd_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .res_ack (res_ack),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .stat    (stat)
  );

  assign res_ack = stat.res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ack) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      m_tdata <= {1'b0, stat.best};
      m_tuser <= ovf_res;
    end
  end

endmodule
